// ===== rtl/core/ddf_pkg.sv =====
// ----------------------------------------------------------------------------
// ddf_pkg
// Shared types, sizes and helpers of the duplicate frame filter.
// ----------------------------------------------------------------------------
package ddf_pkg;

  // ring size and address width of a source node
  localparam int unsigned RING_DEPTH = 32;
  localparam int unsigned ADDR_BITS  = 16;

  // derived widths
  localparam int unsigned IDX_W  = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int unsigned SRC_W  = (ADDR_BITS < 16) ? ADDR_BITS : 16;
  localparam int unsigned SAT_W  = (CNT_W > 7) ? CNT_W : 7;
  localparam int unsigned SLOT_W = 64;
  localparam int unsigned SEQ_W  = 8;
  localparam int unsigned FLD_W  = 6;

  // item kinds
  typedef enum logic [1:0] {
    ACT_CHECK  = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_EXPIRE = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // one stored frame identity
  typedef struct packed {
    logic [SRC_W-1:0]  src;
    logic [SEQ_W-1:0]  seq;
    logic [SLOT_W-1:0] slot;
  } entry_t;

  // one accepted input item
  typedef struct packed {
    action_e           action;
    logic [SRC_W-1:0]  src;
    logic [SEQ_W-1:0]  seq;
    logic [SLOT_W-1:0] slot;
  } item_t;

  // compare unit verdict for one entry
  typedef struct packed {
    logic hit;
    logic expire;
  } cmp_res_t;

  // one result item
  typedef struct packed {
    logic             was_seen;
    logic             inserted;
    logic [FLD_W-1:0] dropped;
    logic [FLD_W-1:0] in_use;
  } result_t;

  // clamp a count to the 6-bit result field
  function automatic logic [FLD_W-1:0] sat_count(input logic [CNT_W-1:0] n);
    logic [SAT_W-1:0] ext;
    ext = SAT_W'(n);
    if (ext > SAT_W'(63)) begin
      return FLD_W'(63);
    end
    return ext[FLD_W-1:0];
  endfunction

endpackage

// ===== rtl/core/ddf_entry_ram.sv =====
// ----------------------------------------------------------------------------
// ddf_entry_ram
// Identity store of the ring: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ddf_entry_ram
  import ddf_pkg::*;
(
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  entry_t           wr_data_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output entry_t           rd_data_o
);

  entry_t mem [RING_DEPTH];
  entry_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/ddf_compare_unit.sv =====
// ----------------------------------------------------------------------------
// ddf_compare_unit
// Shared compare unit: identity match and age test against one entry.
// ----------------------------------------------------------------------------
module ddf_compare_unit
  import ddf_pkg::*;
(
  input  entry_t            entry_i,
  input  item_t             item_i,
  input  logic [SLOT_W-1:0] max_age_i,
  output cmp_res_t          res_o
);

  logic [SLOT_W:0] diff;

  // slot distance, top bit is the borrow when the stored slot is ahead
  assign diff = {1'b0, item_i.slot} - {1'b0, entry_i.slot};

  // identity match
  assign res_o.hit = (entry_i.src == item_i.src) && (entry_i.seq == item_i.seq);

  // old enough to drop: given slot ahead and distance beyond max age
  assign res_o.expire = !diff[SLOT_W] && (diff[SLOT_W-1:0] > max_age_i);

endmodule

// ===== rtl/core/ddf_sequencer.sv =====
// ----------------------------------------------------------------------------
// ddf_sequencer
// Scan sequencer: walks the ring once per item other than a no-op, keeps valid
// marks, counts and the write pointer, and builds the result.
// ----------------------------------------------------------------------------
module ddf_sequencer
  import ddf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  item_t            item_i,
  output item_t            item_o,
  input  cmp_res_t         cmp_i,
  output logic [IDX_W-1:0] rd_addr_o,
  output logic             wr_en_o,
  output logic [IDX_W-1:0] wr_addr_o,
  output entry_t           wr_data_o,
  input  logic             out_free_i,
  output logic             res_load_o,
  output result_t          res_o
);

  state_e                state_q, state_d;
  item_t                 item_q, item_d;
  logic [IDX_W:0]        scan_q, scan_d;
  logic [IDX_W-1:0]      rd_idx_q, rd_idx_d;
  logic                  rd_pend_q, rd_pend_d;
  logic                  hit_q, hit_d;
  logic [CNT_W-1:0]      drop_q, drop_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [IDX_W-1:0]      wptr_q, wptr_d;
  logic [RING_DEPTH-1:0] valid_q, valid_d;
  logic                  scan_done;
  logic                  do_read;
  logic                  do_insert;

  assign scan_done = (scan_q == (IDX_W + 1)'(RING_DEPTH));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (item_i.action == ACT_NOP) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    do_read    = (state_q == ST_SCAN) && !scan_done;
    res_load_o = (state_q == ST_FINISH) && out_free_i;
    do_insert  = res_load_o && (item_q.action == ACT_CHECK) && !hit_q;
  end

  // datapath next values
  always_comb begin
    item_d    = item_q;
    scan_d    = scan_q;
    rd_idx_d  = rd_idx_q;
    rd_pend_d = 1'b0;
    hit_d     = hit_q;
    drop_d    = drop_q;
    cnt_d     = cnt_q;
    wptr_d    = wptr_q;
    valid_d   = valid_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d = item_i;
          scan_d = '0;
          hit_d  = 1'b0;
          drop_d = '0;
        end
      end
      ST_SCAN: begin
        // issue the next read, evaluate the entry read last cycle
        if (do_read) begin
          scan_d    = scan_q + 1'b1;
          rd_idx_d  = scan_q[IDX_W-1:0];
          rd_pend_d = 1'b1;
        end
        if (rd_pend_q && valid_q[rd_idx_q]) begin
          if ((item_q.action == ACT_CHECK || item_q.action == ACT_LOOKUP) && cmp_i.hit) begin
            hit_d = 1'b1;
          end
          if ((item_q.action == ACT_EXPIRE) && cmp_i.expire) begin
            valid_d[rd_idx_q] = 1'b0;
            drop_d            = drop_q + 1'b1;
            cnt_d             = cnt_q - 1'b1;
          end
        end
      end
      ST_FINISH: begin
        // store a new identity at the ring pointer on a check miss
        if (do_insert) begin
          valid_d[wptr_q] = 1'b1;
          if (!valid_q[wptr_q]) begin
            cnt_d = cnt_q + 1'b1;
          end
          wptr_d = (wptr_q == IDX_W'(RING_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_pend_q <= 1'b0;
      cnt_q     <= '0;
      wptr_q    <= '0;
      valid_q   <= '0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_pend_d;
      cnt_q     <= cnt_d;
      wptr_q    <= wptr_d;
      valid_q   <= valid_d;
    end
  end

  // item and scan registers
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    scan_q   <= scan_d;
    rd_idx_q <= rd_idx_d;
    hit_q    <= hit_d;
    drop_q   <= drop_d;
  end

  // memory ports
  assign rd_addr_o      = scan_q[IDX_W-1:0];
  assign wr_en_o        = do_insert;
  assign wr_addr_o      = wptr_q;
  assign wr_data_o.src  = item_q.src;
  assign wr_data_o.seq  = item_q.seq;
  assign wr_data_o.slot = item_q.slot;
  assign item_o         = item_q;

  // result fields
  assign res_o.was_seen = hit_q;
  assign res_o.inserted = (item_q.action == ACT_CHECK) && !hit_q;
  assign res_o.dropped  = sat_count(drop_q);
  assign res_o.in_use   = sat_count(cnt_d);

endmodule

// ===== rtl/core/duplicate_frame_filter.sv =====
// ----------------------------------------------------------------------------
// duplicate_frame_filter
// Duplicate suppression ring cache of recently seen frame identities.
// Each result follows a scan of the ring, which reads one ring entry per cycle
//   through the RAM port, and waits in the sequencer while the output register is full.
// A new item is taken only once the last result is loaded; no-op items skip the scan.
// Reset: all valid marks, the write pointer and the count clear at once,
//   max_age returns to 16; stored identities stay undefined until written.
// ----------------------------------------------------------------------------
module duplicate_frame_filter
  import ddf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write: max_age
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_data_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // source_addr[15:0], seq_num[23:16], time_slot[87:24]
  input  logic [1:0]  s_axis_tuser,  // action[1:0]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // was_seen[0], inserted[1], dropped[7:2], in_use[13:8]
);

  logic [SLOT_W-1:0] max_age_q;
  item_t             in_item;
  item_t             cur_item;
  entry_t            rd_entry;
  entry_t            wr_entry;
  cmp_res_t          cmp_res;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic              wr_en;
  logic              out_free;
  logic              res_load;
  result_t           res;
  result_t           res_q;
  logic              m_valid_q;

  // age register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q <= SLOT_W'(16);
    end else if (cfg_valid_i) begin
      max_age_q <= cfg_data_i;
    end
  end

  // unpack the input transaction
  assign in_item.action = action_e'(s_axis_tuser);
  assign in_item.src    = s_axis_tdata[SRC_W-1:0];
  assign in_item.seq    = s_axis_tdata[23:16];
  assign in_item.slot   = s_axis_tdata[87:24];

  ddf_entry_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_entry),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_entry)
  );

  ddf_compare_unit u_cmp (
    .entry_i   (rd_entry),
    .item_i    (cur_item),
    .max_age_i (max_age_q),
    .res_o     (cmp_res)
  );

  ddf_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .item_i     (in_item),
    .item_o     (cur_item),
    .cmp_i      (cmp_res),
    .rd_addr_o  (rd_addr),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_entry),
    .out_free_i (out_free),
    .res_load_o (res_load),
    .res_o      (res)
  );

  // output register
  assign out_free = !m_valid_q || m_axis_tready;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, res_q.in_use, res_q.dropped, res_q.inserted, res_q.was_seen};

  // a result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!m_valid_q || m_axis_tready))
    else $error("result loaded over a pending transaction");

  // a scanning item gives no result in the cycle after its input transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser != ACT_NOP)) |=> !res_load)
    else $error("result produced too early");

  // a hit never inserts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && res.inserted) |-> !res.was_seen)
    else $error("inserted identity reported as seen");

endmodule
